// File: design/lpht_pkg.sv
// Package for the linear-probing hash table: sizes, record layout, codes.
// Holds the state enum, status codes and the Q0.16 golden-ratio constant.
// Used by linear_probe_hash_table; lpht_ram stands alone.
package lpht_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = SLOT_W + 1;

   localparam int CFG_W       = 9;
   localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 9'd256;

   localparam logic [15:0] GOLDEN_Q16 = 16'd40503;

   localparam int YEAR_W    = 16;
   localparam int KEY_W     = 64;
   localparam int ATTR_W    = 51;
   localparam int REC_W     = KEY_W + KEY_W + ATTR_W;
   localparam int REQ_DATA_W = 184;
   localparam int RSP_DATA_W = 192;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FOUND     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH,
      S_HOME,
      S_INSERT,
      S_FIND
   } state_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_FIND   = 1'b1
   } command_type;

endpackage

// File: design/lpht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No reset; contents undefined until written. No package dependencies.
module lpht_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: design/linear_probe_hash_table.sv
// Linear-probing hash table, one word at a time. After the accepting edge, hashing runs in
// S_HASH (Q0.16 product) and S_HOME (home slot scaling), then the word steps through the
// probed slots, with a last read on a find; a find miss walks all table_size slots.
// A word is taken only in the idle state, so the next word waits until this one is done;
// a result not yet taken holds the finish of the next word. Reset (synchronous, active
// high) clears the occupied bits at once and sets table_size to 256; record RAM is kept.
module linear_probe_hash_table
   import lpht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CFG_W-1:0]      csr_wr_data,   // table_size
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // birth_year, name_key, post_key, birth_day, birth_month, service_years,
   // salary, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,     // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // slot, found_name, found_post, found_year, found_day, found_month,
   // found_service, found_salary, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser      // status
);

   state_type state_ff, state_in;

   logic [CFG_W-1:0]  table_size_ff, table_size_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] live_size;

   command_type        cmd_ff, cmd_in;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [KEY_W-1:0]   name_ff, name_in;
   logic [KEY_W-1:0]   post_ff, post_in;
   logic [ATTR_W-1:0]  attr_ff, attr_in;
   logic [15:0]        frac_ff, frac_in;
   logic [31:0]        hash_prod;
   logic [SIZE_W+15:0] home_prod;

   logic [SLOT_W-1:0] slot_ff, slot_in, slot_next;
   logic [SIZE_W-1:0] count_ff, count_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic              pend_occ_ff, pend_occ_in;

   logic [TABLE_DEPTH-1:0] occ_ff, occ_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   logic [REC_W-1:0] rd_rec;
   logic [KEY_W-1:0] rd_name;
   logic [KEY_W-1:0] rd_post;
   logic [ATTR_W-1:0] rd_attr;

   logic out_free;
   logic probe_end;
   logic slot_free;
   logic hit;
   logic issue;
   logic ins_write;
   logic load;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // table_size 0 behaves as 1, oversize clamps to the table depth
   always_comb begin
      if (table_size_ff == '0) begin
         live_size = SIZE_W'(1);
      end else if (32'(table_size_ff) > 32'(TABLE_DEPTH)) begin
         live_size = SIZE_W'(TABLE_DEPTH);
      end else begin
         live_size = SIZE_W'(table_size_ff);
      end
   end

   assign hash_prod = 32'(year_ff) * 32'(GOLDEN_Q16);
   assign home_prod = (SIZE_W+16)'(size_ff) * (SIZE_W+16)'(frac_ff);

   assign rd_name = rd_rec[KEY_W-1:0];
   assign rd_post = rd_rec[2*KEY_W-1:KEY_W];
   assign rd_attr = rd_rec[REC_W-1:2*KEY_W];

   assign probe_end = (count_ff == size_ff);
   assign slot_free = !occ_ff[slot_ff];
   assign hit       = pend_ff && pend_occ_ff && (rd_name == name_ff)
                      && (rd_attr[YEAR_W-1:0] == year_ff);

   // circular advance within the live size
   always_comb begin
      if ((SIZE_W'(slot_ff) + SIZE_W'(1)) == size_ff) begin
         slot_next = '0;
      end else begin
         slot_next = slot_ff + SLOT_W'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_HASH;
            end
         end
         S_HASH: state_in = S_HOME;
         S_HOME: begin
            if (cmd_ff == CMD_INSERT) begin
               state_in = S_INSERT;
            end else begin
               state_in = S_FIND;
            end
         end
         S_INSERT: begin
            if ((probe_end || slot_free) && out_free) begin
               state_in = S_IDLE;
            end
         end
         S_FIND: begin
            if ((hit || probe_end) && out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      ins_write  = 1'b0;
      load       = 1'b0;
      case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_INSERT: begin
            load      = (probe_end || slot_free) && out_free;
            ins_write = load && !probe_end;
         end
         S_FIND: begin
            load  = (hit || probe_end) && out_free;
            issue = !hit && !probe_end;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      table_size_in = csr_wr_en ? csr_wr_data : table_size_ff;
      cmd_in        = cmd_ff;
      year_in       = year_ff;
      name_in       = name_ff;
      post_in       = post_ff;
      attr_in       = attr_ff;
      size_in       = size_ff;
      frac_in       = frac_ff;
      slot_in       = slot_ff;
      count_in      = count_ff;
      pend_in       = pend_ff;
      pend_slot_in  = pend_slot_ff;
      pend_occ_in   = pend_occ_ff;
      occ_in        = occ_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;

      if (req_tvalid && req_tready) begin
         cmd_in  = command_type'(req_tuser);
         year_in = req_tdata[15:0];
         name_in = req_tdata[79:16];
         post_in = req_tdata[143:80];
         attr_in = {req_tdata[178:144], req_tdata[15:0]};
         size_in = live_size;
      end

      if (state_ff == S_HASH) begin
         frac_in = hash_prod[15:0];
      end

      if (state_ff == S_HOME) begin
         slot_in  = SLOT_W'(home_prod[SIZE_W+15:16]);
         count_in = '0;
         pend_in  = 1'b0;
      end

      if (issue) begin
         slot_in      = slot_next;
         count_in     = count_ff + SIZE_W'(1);
         pend_in      = 1'b1;
         pend_slot_in = slot_ff;
         pend_occ_in  = occ_ff[slot_ff];
      end else if (load) begin
         pend_in = 1'b0;
      end

      if (state_ff == S_INSERT && !probe_end && !slot_free && out_free) begin
         slot_in  = slot_next;
         count_in = count_ff + SIZE_W'(1);
      end

      if (ins_write) begin
         occ_in[slot_ff] = 1'b1;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (state_ff == S_INSERT) begin
            if (probe_end) begin
               rsp_user_in = ST_FULL;
            end else begin
               rsp_user_in      = ST_INSERTED;
               rsp_data_in[7:0] = 8'(slot_ff);
            end
         end else if (hit) begin
            rsp_user_in = ST_FOUND;
            rsp_data_in = {5'd0, rd_attr, rd_post, rd_name, 8'(pend_slot_ff)};
         end else begin
            rsp_user_in = ST_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         table_size_ff <= TABLE_SIZE_RESET;
         occ_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         table_size_ff <= table_size_in;
         occ_ff        <= occ_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      year_ff      <= year_in;
      name_ff      <= name_in;
      post_ff      <= post_in;
      attr_ff      <= attr_in;
      size_ff      <= size_in;
      frac_ff      <= frac_in;
      slot_ff      <= slot_in;
      count_ff     <= count_in;
      pend_slot_ff <= pend_slot_in;
      pend_occ_ff  <= pend_occ_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   // records: name in the low word, then post, then packed attributes
   lpht_ram #(
      .DATA_W (REC_W),
      .DEPTH  (TABLE_DEPTH)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ins_write),
      .wr_addr (slot_ff),
      .wr_data ({attr_ff, post_ff, name_ff}),
      .rd_en   (issue),
      .rd_addr (slot_ff),
      .rd_data (rd_rec)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
